// ===== rtl/ypc_pkg.sv =====
// Shared types, constants and lookup functions for the yaw/pitch camera block.
// Used by ypc_div, ypc_ctrl, ypc_dp and yaw_pitch_camera_update.
package ypc_pkg;

  localparam logic [16:0] DEG360 = 17'd92160;
  localparam logic [16:0] DEG90  = 17'd23040;
  localparam logic [16:0] DEG180 = 17'd46080;
  localparam logic [16:0] DEG270 = 17'd69120;
  localparam logic signed [16:0] PITCH_LIM = 17'sd22784;
  localparam logic [16:0] YAW_RESET = 17'd80640;
  localparam logic signed [15:0] PITCH_RESET = -16'sd5120;

  localparam logic [63:0] PI_Q44 = 64'h3243F6A8885A;
  localparam logic [31:0] PI_LO  = 32'(PI_Q44 & 64'h7FFFFF);
  localparam logic [31:0] PI_HI  = 32'(PI_Q44 >> 23);
  localparam logic [61:0] XBIAS  = 62'd377487360;
  localparam logic [29:0] XDEN   = 30'd754974720;
  localparam logic [30:0] Q30_ONE = 31'h40000000;

  localparam logic [2:0] FN_FWD   = 3'd0;
  localparam logic [2:0] FN_RIGHT = 3'd1;
  localparam logic [2:0] FN_UP    = 3'd2;
  localparam logic [2:0] FN_YAW   = 3'd3;
  localparam logic [2:0] FN_PITCH = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MV_MUL, ST_MV_ADD, ST_YAW, ST_PITCH, ST_LOAD, ST_XLO, ST_XHI,
    ST_XDIV, ST_XWAIT, ST_X2, ST_TSM, ST_TSDIV, ST_TSWAIT, ST_TCM, ST_TCDIV,
    ST_TCWAIT, ST_FIN, ST_BP, ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_MV_MUL, OP_MV_ADD, OP_YAW, OP_PITCH, OP_LOAD, OP_XLO,
    OP_XHI, OP_XDIV, OP_XGET, OP_X2, OP_TSM, OP_TSDIV, OP_TSGET, OP_TCM,
    OP_TCDIV, OP_TCGET, OP_FIN, OP_BP, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] vec;
    logic [1:0] idx;
    logic       ang;
    logic [2:0] k;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_stat_t;

  // Divisors of the sine terms: (2k)(2k+1) for k = 1..8.
  function automatic logic [29:0] sin_den(input logic [2:0] k);
    logic [29:0] d;
    case (k)
      3'd0: d = 30'd6;
      3'd1: d = 30'd20;
      3'd2: d = 30'd42;
      3'd3: d = 30'd72;
      3'd4: d = 30'd110;
      3'd5: d = 30'd156;
      3'd6: d = 30'd210;
      default: d = 30'd272;
    endcase
    return d;
  endfunction

  // Divisors of the cosine terms: (2k-1)(2k) for k = 1..8.
  function automatic logic [29:0] cos_den(input logic [2:0] k);
    logic [29:0] d;
    case (k)
      3'd0: d = 30'd2;
      3'd1: d = 30'd12;
      3'd2: d = 30'd30;
      3'd3: d = 30'd56;
      3'd4: d = 30'd90;
      3'd5: d = 30'd132;
      3'd6: d = 30'd182;
      default: d = 30'd240;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/ypc_div.sv =====
// Divider by the fixed angle and series constants: each divisor is a power of two
// times an odd factor, divided by a reciprocal multiply and one correction step.
// Registers m, plo/phi, qest, quot in turn. Uses ypc_pkg; instantiated by ypc_dp.
module ypc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [61:0] dividend,
  input  logic [29:0] divisor,
  output logic [31:0] quot,
  output logic        done
);
  logic [4:0]  a_sel;
  logic [6:0]  o_sel;
  logic [31:0] m_sel;
  logic        wide_sel;
  logic [36:0] m;
  logic [6:0]  o;
  logic [31:0] mrec;
  logic        wide;
  logic [63:0] plo;
  logic [36:0] phi;
  logic [31:0] qest;
  logic        v1, v2, v3;
  logic [68:0] sum;
  logic [38:0] qo;
  logic [38:0] rem;

  // The reciprocal is rounded down, so the estimate is low by at most one.
  always_comb begin
    a_sel    = 5'd0;
    o_sel    = 7'd1;
    m_sel    = 32'hFFFFFFFF;
    wide_sel = 1'b0;
    case (divisor)
      ypc_pkg::XDEN: begin
        a_sel = 5'd24; o_sel = 7'd45; m_sel = 32'd3054198966; wide_sel = 1'b1;
      end
      30'd6:   begin a_sel = 5'd1; o_sel = 7'd3;   m_sel = 32'd1431655765; end
      30'd20:  begin a_sel = 5'd2; o_sel = 7'd5;   m_sel = 32'd858993459;  end
      30'd42:  begin a_sel = 5'd1; o_sel = 7'd21;  m_sel = 32'd204522252;  end
      30'd72:  begin a_sel = 5'd3; o_sel = 7'd9;   m_sel = 32'd477218588;  end
      30'd110: begin a_sel = 5'd1; o_sel = 7'd55;  m_sel = 32'd78090314;   end
      30'd156: begin a_sel = 5'd2; o_sel = 7'd39;  m_sel = 32'd110127366;  end
      30'd210: begin a_sel = 5'd1; o_sel = 7'd105; m_sel = 32'd40904450;   end
      30'd272: begin a_sel = 5'd4; o_sel = 7'd17;  m_sel = 32'd252645135;  end
      30'd2:   begin a_sel = 5'd1; o_sel = 7'd1;   m_sel = 32'hFFFFFFFF;   end
      30'd12:  begin a_sel = 5'd2; o_sel = 7'd3;   m_sel = 32'd1431655765; end
      30'd30:  begin a_sel = 5'd1; o_sel = 7'd15;  m_sel = 32'd286331153;  end
      30'd56:  begin a_sel = 5'd3; o_sel = 7'd7;   m_sel = 32'd613566756;  end
      30'd90:  begin a_sel = 5'd1; o_sel = 7'd45;  m_sel = 32'd95443717;   end
      30'd132: begin a_sel = 5'd2; o_sel = 7'd33;  m_sel = 32'd130150524;  end
      30'd182: begin a_sel = 5'd1; o_sel = 7'd91;  m_sel = 32'd47197442;   end
      30'd240: begin a_sel = 5'd4; o_sel = 7'd15;  m_sel = 32'd286331153;  end
      default: ;
    endcase
  end

  always_comb begin
    sum = {phi, 32'd0} + 69'(plo);
    qo  = 39'(qest) * 39'(o);
    rem = 39'(m) - qo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      m    <= 37'(dividend >> a_sel);
      o    <= o_sel;
      mrec <= m_sel;
      wide <= wide_sel;
    end
    if (v1) begin
      plo <= m[31:0] * mrec;
      phi <= 37'(m[36:32] * mrec);
    end
    if (v2) qest <= wide ? sum[68:37] : sum[63:32];
    if (v3) quot <= (rem >= 39'(o)) ? qest + 32'd1 : qest;
  end
endmodule

// ===== rtl/ypc_ctrl.sv =====
// Sequencer of the camera block: steps the datapath through moves, angle updates,
// the series evaluation of sine and cosine and the basis products. Uses ypc_pkg.
module ypc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        func,
  input  ypc_pkg::dp_stat_t stat,
  output ypc_pkg::dp_cmd_t  cmd
);
  ypc_pkg::state_t state, state_next;
  logic [2:0] func_q;
  logic [1:0] idx;
  logic [2:0] k;
  logic       ang;
  logic       init;

  always_comb begin
    state_next = state;
    case (state)
      ypc_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (func == ypc_pkg::FN_FWD || func == ypc_pkg::FN_RIGHT ||
              func == ypc_pkg::FN_UP)      state_next = ypc_pkg::ST_MV_MUL;
          else if (func == ypc_pkg::FN_YAW)   state_next = ypc_pkg::ST_YAW;
          else if (func == ypc_pkg::FN_PITCH) state_next = ypc_pkg::ST_PITCH;
          else                                state_next = ypc_pkg::ST_DONE;
        end
      end
      ypc_pkg::ST_MV_MUL: state_next = ypc_pkg::ST_MV_ADD;
      ypc_pkg::ST_MV_ADD: state_next = (idx == 2'd2) ? ypc_pkg::ST_DONE : ypc_pkg::ST_MV_MUL;
      ypc_pkg::ST_YAW:    state_next = ypc_pkg::ST_LOAD;
      ypc_pkg::ST_PITCH:  state_next = ypc_pkg::ST_LOAD;
      ypc_pkg::ST_LOAD:   state_next = ypc_pkg::ST_XLO;
      ypc_pkg::ST_XLO:    state_next = ypc_pkg::ST_XHI;
      ypc_pkg::ST_XHI:    state_next = ypc_pkg::ST_XDIV;
      ypc_pkg::ST_XDIV:   state_next = ypc_pkg::ST_XWAIT;
      ypc_pkg::ST_XWAIT:  if (stat.div_done) state_next = ypc_pkg::ST_X2;
      ypc_pkg::ST_X2:     state_next = ypc_pkg::ST_TSM;
      ypc_pkg::ST_TSM:    state_next = ypc_pkg::ST_TSDIV;
      ypc_pkg::ST_TSDIV:  state_next = ypc_pkg::ST_TSWAIT;
      ypc_pkg::ST_TSWAIT: if (stat.div_done) state_next = ypc_pkg::ST_TCM;
      ypc_pkg::ST_TCM:    state_next = ypc_pkg::ST_TCDIV;
      ypc_pkg::ST_TCDIV:  state_next = ypc_pkg::ST_TCWAIT;
      ypc_pkg::ST_TCWAIT: begin
        if (stat.div_done) state_next = (k == 3'd7) ? ypc_pkg::ST_FIN : ypc_pkg::ST_TSM;
      end
      ypc_pkg::ST_FIN:    state_next = ang ? ypc_pkg::ST_BP : ypc_pkg::ST_LOAD;
      ypc_pkg::ST_BP: begin
        if (idx == 2'd3) state_next = init ? ypc_pkg::ST_IDLE : ypc_pkg::ST_DONE;
      end
      ypc_pkg::ST_DONE:   if (stat.out_free) state_next = ypc_pkg::ST_IDLE;
      default:            state_next = ypc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.vec = func_q[1:0];
    cmd.idx = idx;
    cmd.ang = ang;
    cmd.k   = k;
    cmd.op  = ypc_pkg::OP_NONE;
    case (state)
      ypc_pkg::ST_IDLE:   cmd.op = in_valid ? ypc_pkg::OP_LATCH : ypc_pkg::OP_NONE;
      ypc_pkg::ST_MV_MUL: cmd.op = ypc_pkg::OP_MV_MUL;
      ypc_pkg::ST_MV_ADD: cmd.op = ypc_pkg::OP_MV_ADD;
      ypc_pkg::ST_YAW:    cmd.op = ypc_pkg::OP_YAW;
      ypc_pkg::ST_PITCH:  cmd.op = ypc_pkg::OP_PITCH;
      ypc_pkg::ST_LOAD:   cmd.op = ypc_pkg::OP_LOAD;
      ypc_pkg::ST_XLO:    cmd.op = ypc_pkg::OP_XLO;
      ypc_pkg::ST_XHI:    cmd.op = ypc_pkg::OP_XHI;
      ypc_pkg::ST_XDIV:   cmd.op = ypc_pkg::OP_XDIV;
      ypc_pkg::ST_XWAIT:  cmd.op = stat.div_done ? ypc_pkg::OP_XGET : ypc_pkg::OP_NONE;
      ypc_pkg::ST_X2:     cmd.op = ypc_pkg::OP_X2;
      ypc_pkg::ST_TSM:    cmd.op = ypc_pkg::OP_TSM;
      ypc_pkg::ST_TSDIV:  cmd.op = ypc_pkg::OP_TSDIV;
      ypc_pkg::ST_TSWAIT: cmd.op = stat.div_done ? ypc_pkg::OP_TSGET : ypc_pkg::OP_NONE;
      ypc_pkg::ST_TCM:    cmd.op = ypc_pkg::OP_TCM;
      ypc_pkg::ST_TCDIV:  cmd.op = ypc_pkg::OP_TCDIV;
      ypc_pkg::ST_TCWAIT: cmd.op = stat.div_done ? ypc_pkg::OP_TCGET : ypc_pkg::OP_NONE;
      ypc_pkg::ST_FIN:    cmd.op = ypc_pkg::OP_FIN;
      ypc_pkg::ST_BP:     cmd.op = ypc_pkg::OP_BP;
      ypc_pkg::ST_DONE:   cmd.op = stat.out_free ? ypc_pkg::OP_OUT : ypc_pkg::OP_NONE;
      default:            cmd.op = ypc_pkg::OP_NONE;
    endcase
  end

  assign in_stall = (state != ypc_pkg::ST_IDLE);

  // After reset the basis is built from the reset angles before any request is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ypc_pkg::ST_LOAD;
      init   <= 1'b1;
      ang    <= 1'b0;
      idx    <= 2'd0;
      k      <= 3'd0;
      func_q <= ypc_pkg::FN_FWD;
    end else begin
      state <= state_next;
      case (state)
        ypc_pkg::ST_IDLE: begin
          if (in_valid) begin
            func_q <= func;
            idx    <= 2'd0;
            ang    <= 1'b0;
          end
        end
        ypc_pkg::ST_MV_ADD: idx <= idx + 2'd1;
        ypc_pkg::ST_X2:     k <= 3'd0;
        ypc_pkg::ST_TCWAIT: if (stat.div_done) k <= k + 3'd1;
        ypc_pkg::ST_FIN: begin
          ang <= 1'b1;
          idx <= 2'd0;
        end
        ypc_pkg::ST_BP: begin
          idx <= idx + 2'd1;
          if (idx == 2'd3) init <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/ypc_dp.sv =====
// Datapath of the camera block: position, angles, series evaluation and basis.
// Uses ypc_pkg and instantiates ypc_div.
module ypc_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  ypc_pkg::dp_cmd_t         cmd,
  output ypc_pkg::dp_stat_t        stat,
  input  logic signed [15:0]       amount,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic signed [31:0]       out_pos [3],
  output logic signed [15:0]       out_basis [9]
);
  logic signed [31:0] pos [3];
  logic [16:0]        yaw;
  logic signed [15:0] pitch;
  logic signed [15:0] basis [9];
  logic signed [15:0] amt;
  logic signed [31:0] mprod;
  logic [1:0]         quad;
  logic [14:0]        r;
  logic [61:0]        num;
  logic [30:0]        x;
  logic [31:0]        x2;
  logic [30:0]        ts;
  logic [30:0]        tc;
  logic [32:0]        tmp;
  logic signed [33:0] s;
  logic signed [33:0] c;
  logic signed [15:0] sy, cy, sp, cp;

  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod64;
  logic signed [15:0] sm_a, sm_b;
  logic signed [31:0] sm_p;
  logic signed [31:0] sm_rnd;
  logic signed [15:0] m14;
  logic [3:0]         bidx;
  logic signed [31:0] mv_d;
  logic signed [32:0] mv_sum;
  logic signed [31:0] mv_sat;
  logic signed [18:0] ysum;
  logic [16:0]        ywrap;
  logic signed [16:0] psum;
  logic signed [15:0] pclamp;
  logic [16:0]        pext;
  logic [16:0]        red;
  logic               div_start;
  logic [61:0]        div_dvd;
  logic [29:0]        div_dsr;
  logic [31:0]        quot;
  logic               div_done;
  logic signed [33:0] qext;
  logic [14:0]        sq, cq;
  logic signed [15:0] s_fin, c_fin;

  // Clamp a Q30 value to [0, 1] and round it to Q1.14.
  function automatic logic [14:0] q30_to_q14(input logic signed [33:0] v);
    logic [30:0] cl;
    logic [31:0] sum;
    if (v < 0) cl = 31'd0;
    else if (v > $signed({3'b0, ypc_pkg::Q30_ONE})) cl = ypc_pkg::Q30_ONE;
    else cl = v[30:0];
    sum = {1'b0, cl} + 32'h8000;
    return sum[30:16];
  endfunction

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (cmd.op)
      ypc_pkg::OP_XLO: begin mul_a = 32'(r);  mul_b = ypc_pkg::PI_LO; end
      ypc_pkg::OP_XHI: begin mul_a = 32'(r);  mul_b = ypc_pkg::PI_HI; end
      ypc_pkg::OP_X2:  begin mul_a = 32'(x);  mul_b = 32'(x);         end
      ypc_pkg::OP_TSM: begin mul_a = 32'(ts); mul_b = x2;             end
      ypc_pkg::OP_TCM: begin mul_a = 32'(tc); mul_b = x2;             end
      default: ;
    endcase
    prod64 = mul_a * mul_b;
  end

  always_comb begin
    bidx = 4'(cmd.vec) * 4'd3 + 4'(cmd.idx);
    sm_a = 16'sd0;
    sm_b = 16'sd0;
    case (cmd.op)
      ypc_pkg::OP_MV_MUL: begin sm_a = basis[bidx]; sm_b = amt; end
      ypc_pkg::OP_BP: begin
        case (cmd.idx)
          2'd0:    begin sm_a = cp; sm_b = sy; end
          2'd1:    begin sm_a = cp; sm_b = cy; end
          2'd2:    begin sm_a = sy; sm_b = sp; end
          default: begin sm_a = cy; sm_b = sp; end
        endcase
      end
      default: ;
    endcase
    sm_p   = sm_a * sm_b;
    // Rounding to nearest with ties away from zero.
    sm_rnd = (sm_p >= 0) ? ((sm_p + 32'sd8192) >>> 14) : ((sm_p + 32'sd8191) >>> 14);
    m14    = sm_rnd[15:0];
  end

  always_comb begin
    mv_d   = (mprod >= 0) ? ((mprod + 32'sd32) >>> 6) : ((mprod + 32'sd31) >>> 6);
    mv_sum = 33'(pos[cmd.idx]) + 33'(mv_d);
    if (mv_sum[32] != mv_sum[31]) mv_sat = mv_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    else mv_sat = mv_sum[31:0];
  end

  always_comb begin
    ysum = $signed({2'b0, yaw}) + 19'(amt);
    if (ysum < 0) ywrap = 17'(ysum + $signed({2'b0, ypc_pkg::DEG360}));
    else if (ysum >= $signed({2'b0, ypc_pkg::DEG360}))
      ywrap = 17'(ysum - $signed({2'b0, ypc_pkg::DEG360}));
    else ywrap = ysum[16:0];
    psum = 17'(pitch) + 17'(amt);
    if (psum > ypc_pkg::PITCH_LIM) pclamp = 16'(ypc_pkg::PITCH_LIM);
    else if (psum < -ypc_pkg::PITCH_LIM) pclamp = 16'(-ypc_pkg::PITCH_LIM);
    else pclamp = psum[15:0];
    pext = 17'(pitch);
    if (cmd.ang) red = (pitch < 0) ? pext + ypc_pkg::DEG360 : pext;
    else red = yaw;
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = num;
    div_dsr   = ypc_pkg::XDEN;
    case (cmd.op)
      ypc_pkg::OP_XDIV: div_start = 1'b1;
      ypc_pkg::OP_TSDIV: begin
        div_start = 1'b1;
        div_dvd   = 62'(tmp);
        div_dsr   = ypc_pkg::sin_den(cmd.k);
      end
      ypc_pkg::OP_TCDIV: begin
        div_start = 1'b1;
        div_dvd   = 62'(tmp);
        div_dsr   = ypc_pkg::cos_den(cmd.k);
      end
      default: ;
    endcase
  end

  ypc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .quot     (quot),
    .done     (div_done)
  );

  always_comb begin
    qext = $signed({2'b0, quot});
    sq   = q30_to_q14(s);
    cq   = q30_to_q14(c);
    case (quad)
      2'd0:    begin s_fin = 16'({1'b0, sq});  c_fin = 16'({1'b0, cq});  end
      2'd1:    begin s_fin = 16'({1'b0, cq});  c_fin = -16'({1'b0, sq}); end
      2'd2:    begin s_fin = -16'({1'b0, sq}); c_fin = -16'({1'b0, cq}); end
      default: begin s_fin = -16'({1'b0, cq}); c_fin = 16'({1'b0, sq});  end
    endcase
  end

  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos[0]    <= 32'sd0;
      pos[1]    <= 32'sd0;
      pos[2]    <= 32'sd0;
      yaw       <= ypc_pkg::YAW_RESET;
      pitch     <= ypc_pkg::PITCH_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == ypc_pkg::OP_OUT) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (cmd.op)
        ypc_pkg::OP_MV_ADD: pos[cmd.idx] <= mv_sat;
        ypc_pkg::OP_YAW:    yaw <= ywrap;
        ypc_pkg::OP_PITCH:  pitch <= pclamp;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      ypc_pkg::OP_LATCH:  amt <= amount;
      ypc_pkg::OP_MV_MUL: mprod <= sm_p;
      ypc_pkg::OP_LOAD: begin
        if (red >= ypc_pkg::DEG270) begin
          quad <= 2'd3; r <= 15'(red - ypc_pkg::DEG270);
        end else if (red >= ypc_pkg::DEG180) begin
          quad <= 2'd2; r <= 15'(red - ypc_pkg::DEG180);
        end else if (red >= ypc_pkg::DEG90) begin
          quad <= 2'd1; r <= 15'(red - ypc_pkg::DEG90);
        end else begin
          quad <= 2'd0; r <= red[14:0];
        end
      end
      ypc_pkg::OP_XLO: num <= 62'(prod64) + ypc_pkg::XBIAS;
      ypc_pkg::OP_XHI: num <= num + 62'(prod64 << 23);
      ypc_pkg::OP_XGET: x <= quot[30:0];
      ypc_pkg::OP_X2: begin
        x2 <= prod64[61:30];
        ts <= x;
        tc <= ypc_pkg::Q30_ONE;
        s  <= $signed({3'b0, x});
        c  <= $signed({3'b0, ypc_pkg::Q30_ONE});
      end
      ypc_pkg::OP_TSM: tmp <= prod64[62:30];
      ypc_pkg::OP_TCM: tmp <= prod64[62:30];
      // Terms alternate in sign, starting with a subtraction for the first term.
      ypc_pkg::OP_TSGET: begin
        ts <= quot[30:0];
        s  <= cmd.k[0] ? s + qext : s - qext;
      end
      ypc_pkg::OP_TCGET: begin
        tc <= quot[30:0];
        c  <= cmd.k[0] ? c + qext : c - qext;
      end
      ypc_pkg::OP_FIN: begin
        if (cmd.ang) begin
          sp <= s_fin; cp <= c_fin;
        end else begin
          sy <= s_fin; cy <= c_fin;
        end
      end
      ypc_pkg::OP_BP: begin
        case (cmd.idx)
          2'd0: begin
            basis[0] <= m14;
            basis[1] <= sp;
            basis[3] <= -cy;
            basis[4] <= 16'sd0;
            basis[5] <= sy;
            basis[7] <= cp;
          end
          2'd1:    basis[2] <= m14;
          2'd2:    basis[6] <= -m14;
          default: basis[8] <= -m14;
        endcase
      end
      ypc_pkg::OP_OUT: begin
        out_pos   <= pos;
        out_basis <= basis;
      end
      default: ;
    endcase
  end
endmodule

// ===== rtl/yaw_pitch_camera_update.sv =====
// Yaw/pitch fly camera. Rotation time is set by two sine/cosine series of 17 constant
// divides each plus the multiplies. Unused codes go straight to the result. One
// request is in work at a time; a finished result waits in an output register while
// the next request is taken. Synchronous reset restores position and angles and then
// builds the basis from the reset angles, stalling requests.
module yaw_pitch_camera_update (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         func,
  input  logic signed [15:0] amount,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [15:0] fwd_x,
  output logic signed [15:0] fwd_y,
  output logic signed [15:0] fwd_z,
  output logic signed [15:0] rgt_x,
  output logic signed [15:0] rgt_y,
  output logic signed [15:0] rgt_z,
  output logic signed [15:0] upv_x,
  output logic signed [15:0] upv_y,
  output logic signed [15:0] upv_z
);
  ypc_pkg::dp_cmd_t   cmd;
  ypc_pkg::dp_stat_t  stat;
  logic signed [31:0] out_pos [3];
  logic signed [15:0] out_basis [9];

  ypc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .func     (func),
    .stat     (stat),
    .cmd      (cmd)
  );

  ypc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .amount    (amount),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_pos   (out_pos),
    .out_basis (out_basis)
  );

  assign pos_x = out_pos[0];
  assign pos_y = out_pos[1];
  assign pos_z = out_pos[2];
  assign fwd_x = out_basis[0];
  assign fwd_y = out_basis[1];
  assign fwd_z = out_basis[2];
  assign rgt_x = out_basis[3];
  assign rgt_y = out_basis[4];
  assign rgt_z = out_basis[5];
  assign upv_x = out_basis[6];
  assign upv_y = out_basis[7];
  assign upv_z = out_basis[8];
endmodule
